// ===== rtl/lgg_pkg.sv =====
// Shared types and constants for the life grid generation block.
// Holds the transfer structs, command and register codes, and the sequencer states.
// No dependencies.
`default_nettype none

package lgg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL = 7'd64;

  // Command codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // B3/S23 neighbor counts
  localparam logic [3:0] NBR_KEEP  = 4'd2;
  localparam logic [3:0] NBR_BIRTH = 4'd3;

  localparam int GEN_W = 32;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive_in;
  } in_item_t;

  typedef struct packed {
    logic             cell_alive;
    logic             all_dead;
    logic [GEN_W-1:0] generation;
    logic             bad_index;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_UPD,
    ST_SWEEP,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/life_grid_generation.sv =====
// Life grid (B3/S23): write cell is a read-modify-write of one grid row in memory, read
//   cell a read of one row; a new command is taken only once the last result is loaded.
// Step walks the active rows one per cycle through the row memory, then a slot for the
//   dead row below; a new command is taken only once the step result is loaded.
// After a row or column count write, the first command is preceded by a rescan of the rows.
// Synchronous reset clears the grid by a pass over all MAX_ROWS rows; no command taken meanwhile.
`default_nettype none

module life_grid_generation #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lgg_pkg::in_item_t             in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lgg_pkg::out_item_t                 out_data,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lgg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lgg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lgg_pkg::*;

  localparam int AW   = $clog2(MAX_ROWS);      // row address
  localparam int CW_R = $clog2(MAX_ROWS + 1);  // active row count
  localparam int CW_C = $clog2(MAX_COLS + 1);  // active column count
  localparam int CIW  = $clog2(MAX_COLS);      // column select

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                state_r,    state_nxt;
  logic [CFG_DATA_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [CFG_DATA_W-1:0] cols_cfg_r, cols_cfg_nxt;
  logic                  stale_r,    stale_nxt;   // live-row count needs a rescan
  in_item_t              cmd_r,      cmd_nxt;
  logic                  cell_r,     cell_nxt;
  logic [GEN_W-1:0]      gen_r,      gen_nxt;
  logic [CW_R-1:0]       live_r,     live_nxt;    // active rows holding a live cell
  logic [AW-1:0]         clr_idx_r,  clr_idx_nxt;
  // sweep engine
  logic [CW_R-1:0]       iss_idx_r,  iss_idx_nxt;
  logic                  iss_act_r,  iss_act_nxt;
  logic [CW_R-1:0]       arr_idx_r,  arr_idx_nxt;
  logic                  arr_vld_r,  arr_vld_nxt;
  logic [MAX_COLS-1:0]   up_r,       up_nxt;      // old row k-2
  logic [MAX_COLS-1:0]   mid_r,      mid_nxt;     // old row k-1
  logic [CW_R-1:0]       cnt_r,      cnt_nxt;
  logic                  commit_r,   commit_nxt;  // 1: step, 0: rescan only
  // result buffer
  logic                  out_vld_r,  out_vld_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Memory port
  // ---------------------------------------------------------------------------
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [MAX_COLS-1:0] mem_rdata;

  lgg_grid_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Active grid size: zero acts as one, above the maximum acts as the maximum
  // ---------------------------------------------------------------------------
  logic [CW_R-1:0]     nr;
  logic [CW_C-1:0]     nc;
  logic [MAX_COLS-1:0] col_mask;

  always_comb begin
    if (rows_cfg_r == '0) begin
      nr = CW_R'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      nr = CW_R'(MAX_ROWS);
    end else begin
      nr = CW_R'(rows_cfg_r);
    end
  end

  always_comb begin
    if (cols_cfg_r == '0) begin
      nc = CW_C'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      nc = CW_C'(MAX_COLS);
    end else begin
      nc = CW_C'(cols_cfg_r);
    end
  end

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = (CW_C'(c) < nc);
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  function automatic logic is_bad(input in_item_t item, input logic [CW_R-1:0] n_r,
                                  input logic [CW_C-1:0] n_c);
    logic acc;
    acc = (item.opcode == OP_WRITE) || (item.opcode == OP_READ);
    return acc && ((32'(item.row) >= 32'(n_r)) || (32'(item.col) >= 32'(n_c)));
  endfunction

  // First state after a command is taken; a pending rescan always goes first
  function automatic state_t route(input in_item_t item, input logic stale,
                                   input logic [CW_R-1:0] n_r, input logic [CW_C-1:0] n_c);
    state_t st;
    st = ST_RESP;
    if (stale) begin
      st = ST_SWEEP;
    end else begin
      case (item.opcode)
        OP_WRITE, OP_READ: st = is_bad(item, n_r, n_c) ? ST_RESP : ST_ACC;
        OP_STEP:           st = ST_SWEEP;
        default:           st = ST_RESP;
      endcase
    end
    return st;
  endfunction

  logic            in_fire;
  logic            out_load;
  logic            clr_last;
  logic            sweep_end;
  state_t          in_route;
  state_t          cmd_route;
  logic [AW-1:0]   row_a;
  logic [CIW-1:0]  col_a;

  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_RESP) && (!out_vld_r || out_ready);
  assign clr_last  = (clr_idx_r == AW'(MAX_ROWS - 1));
  assign sweep_end = (state_r == ST_SWEEP) && arr_vld_r && (arr_idx_r == nr);
  assign in_route  = route(in_data, stale_r, nr, nc);
  assign cmd_route = route(cmd_r, 1'b0, nr, nc);
  assign row_a     = AW'(cmd_r.row);
  assign col_a     = CIW'(cmd_r.col);

  // ---------------------------------------------------------------------------
  // Sweep row datapath
  // ---------------------------------------------------------------------------
  logic [MAX_COLS-1:0] arr_raw;     // old row k; the row below the grid is dead
  logic [MAX_COLS-1:0] calc_row;
  logic [MAX_COLS-1:0] merged_row;  // new cells inside, stored cells kept outside

  assign arr_raw = (arr_idx_r == nr) ? '0 : mem_rdata;

  lgg_row_calc #(
    .COLS (MAX_COLS)
  ) u_calc (
    .up_row  (up_r    & col_mask),
    .mid_row (mid_r   & col_mask),
    .dn_row  (arr_raw & col_mask),
    .nxt_row (calc_row)
  );

  assign merged_row = (calc_row & col_mask) | (mid_r & ~col_mask);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = in_route;
      ST_ACC:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_RESP;
      ST_SWEEP: begin
        if (sweep_end) begin
          state_nxt = commit_r ? ST_RESP : cmd_route;
        end
      end
      ST_RESP:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs and datapath
  // ---------------------------------------------------------------------------
  logic                start_sweep;
  logic                upd_old_nz;
  logic                upd_new_nz;
  logic [MAX_COLS-1:0] upd_row;
  logic [CW_R-1:0]     cnt_sum;

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    stale_nxt    = stale_r;
    cmd_nxt      = cmd_r;
    cell_nxt     = cell_r;
    gen_nxt      = gen_r;
    live_nxt     = live_r;
    clr_idx_nxt  = clr_idx_r;
    iss_idx_nxt  = iss_idx_r;
    iss_act_nxt  = iss_act_r;
    arr_idx_nxt  = arr_idx_r;
    arr_vld_nxt  = arr_vld_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    cnt_nxt      = cnt_r;
    commit_nxt   = commit_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;

    mem_we    = 1'b0;
    mem_waddr = row_a;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = row_a;

    start_sweep = 1'b0;
    upd_row     = mem_rdata;
    upd_row[col_a] = cmd_r.alive_in;
    upd_old_nz  = |(mem_rdata & col_mask);
    upd_new_nz  = |(upd_row & col_mask);
    cnt_sum     = cnt_r;

    // Configuration: any size change invalidates the live-row count
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: begin
          rows_cfg_nxt = cfg_data;
          stale_nxt    = 1'b1;
        end
        REG_COLS: begin
          cols_cfg_nxt = cfg_data;
          stale_nxt    = 1'b1;
        end
        default: ;
      endcase
    end

    // Drop the result once the far side takes it
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + AW'(1);
      end

      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_data;
          cell_nxt = 1'b0;
          if (in_route == ST_SWEEP) begin
            start_sweep = 1'b1;
            commit_nxt  = !stale_r;
          end
        end
      end

      ST_ACC: begin
        mem_re    = 1'b1;
        mem_raddr = row_a;
      end

      ST_UPD: begin
        if (cmd_r.opcode == OP_READ) begin
          cell_nxt = mem_rdata[col_a];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = row_a;
          mem_wdata = upd_row;
          if (upd_old_nz && !upd_new_nz) begin
            live_nxt = live_r - CW_R'(1);
          end else if (!upd_old_nz && upd_new_nz) begin
            live_nxt = live_r + CW_R'(1);
          end
        end
      end

      ST_SWEEP: begin
        // Issue: read rows 0 .. nr-1, then one slot for the dead row below
        arr_vld_nxt = iss_act_r;
        arr_idx_nxt = iss_idx_r;
        if (iss_act_r) begin
          mem_re      = (iss_idx_r < nr);
          mem_raddr   = AW'(iss_idx_r);
          iss_idx_nxt = iss_idx_r + CW_R'(1);
          if (iss_idx_r == nr) begin
            iss_act_nxt = 1'b0;
          end
        end

        // Arrival of old row k: row k-1 now has all three neighbors
        if (arr_vld_r) begin
          if (commit_r) begin
            if (arr_idx_r != '0) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(arr_idx_r - CW_R'(1));
              mem_wdata = merged_row;
              if (|(calc_row & col_mask)) begin
                cnt_sum = cnt_r + CW_R'(1);
              end
            end
          end else if (arr_idx_r != nr) begin
            if (|(arr_raw & col_mask)) begin
              cnt_sum = cnt_r + CW_R'(1);
            end
          end
          cnt_nxt = cnt_sum;
          up_nxt  = mid_r;
          mid_nxt = arr_raw;
        end

        if (sweep_end) begin
          live_nxt = cnt_sum;
          if (commit_r) begin
            if (gen_r != '1) begin
              gen_nxt = gen_r + GEN_W'(1);
            end
          end else begin
            stale_nxt = 1'b0;
            if (cmd_route == ST_SWEEP) begin
              start_sweep = 1'b1;
              commit_nxt  = 1'b1;
            end
          end
        end
      end

      ST_RESP: begin
        if (out_load) begin
          out_vld_nxt             = 1'b1;
          out_data_nxt.cell_alive = cell_r;
          out_data_nxt.all_dead   = (live_r == '0);
          out_data_nxt.generation = gen_r;
          out_data_nxt.bad_index  = is_bad(cmd_r, nr, nc);
        end
      end

      default: ;
    endcase

    // Fresh sweep: window starts with the dead row above the grid
    if (start_sweep) begin
      iss_idx_nxt = '0;
      iss_act_nxt = 1'b1;
      arr_vld_nxt = 1'b0;
      up_nxt      = '0;
      mid_nxt     = '0;
      cnt_nxt     = '0;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      rows_cfg_r <= CFG_RESET_VAL;
      cols_cfg_r <= CFG_RESET_VAL;
      stale_r    <= 1'b0;
      gen_r      <= '0;
      live_r     <= '0;
      clr_idx_r  <= '0;
      iss_act_r  <= 1'b0;
      arr_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      stale_r    <= stale_nxt;
      gen_r      <= gen_nxt;
      live_r     <= live_nxt;
      clr_idx_r  <= clr_idx_nxt;
      iss_act_r  <= iss_act_nxt;
      arr_vld_r  <= arr_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cell_r     <= cell_nxt;
    iss_idx_r  <= iss_idx_nxt;
    arr_idx_r  <= arr_idx_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    cnt_r      <= cnt_nxt;
    commit_r   <= commit_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !stale_r) |-> (32'(live_r) <= 32'(nr)))
    else $error("live-row count exceeds active rows");

  a_sweep_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && mem_we) |-> (32'(mem_waddr) < 32'(nr)))
    else $error("step writes a row outside the active grid");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_RESP))
    else $error("result raised outside the response state");

  a_gen_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (gen_r >= $past(gen_r)))
    else $error("generation count went backward");
`endif

endmodule

`default_nettype wire

// ===== rtl/lgg_grid_mem.sv =====
// Grid storage: one row of cells per entry, one write and one read port.
// Read data is registered, so it appears in the cycle after the read request.
// No dependencies.
`default_nettype none

module lgg_grid_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/lgg_row_calc.sv =====
// Next-generation row from three neighboring rows, one lane per column.
// Inputs arrive already masked to the active columns; outside cells read as dead.
// Depends on lgg_pkg for the B3/S23 neighbor counts.
`default_nettype none

module lgg_row_calc #(
  parameter int COLS = 64
) (
  input  wire logic [COLS-1:0] up_row,
  input  wire logic [COLS-1:0] mid_row,
  input  wire logic [COLS-1:0] dn_row,
  output logic      [COLS-1:0] nxt_row
);

  import lgg_pkg::*;

  logic [COLS+1:0] up_x;
  logic [COLS+1:0] mid_x;
  logic [COLS+1:0] dn_x;

  // Pad with a dead cell on each side
  assign up_x  = {1'b0, up_row,  1'b0};
  assign mid_x = {1'b0, mid_row, 1'b0};
  assign dn_x  = {1'b0, dn_row,  1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic [3:0] nbr;

    assign nbr = 4'(up_x[c])  + 4'(up_x[c+1]) + 4'(up_x[c+2]) +
                 4'(mid_x[c])                 + 4'(mid_x[c+2]) +
                 4'(dn_x[c])  + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);

    assign nxt_row[c] = (nbr == NBR_BIRTH) || (mid_row[c] && (nbr == NBR_KEEP));
  end

endmodule

`default_nettype wire

// ===== tb/life_grid_checker.sv =====
// Result checker for the life grid block: watches the command, result and register channels.
// Keeps its own grid, generation count and size registers and compares every result.
// Depends on lgg_pkg for the transfer structs, command codes and register codes.
module life_grid_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  lgg_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  lgg_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lgg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            errors,
  output int                            outstanding
);
  import lgg_pkg::*;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  logic [GRID_COLS-1:0]  cells [GRID_ROWS];
  logic [GEN_W-1:0]      gen_count;
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  out_item_t             pending_results [$];
  int                    fail_count = 0;

  assign errors = fail_count;

  function automatic int active_size(input logic [CFG_DATA_W-1:0] value, input int limit);
    if (value == '0) return 1;
    if (int'(value) > limit) return limit;
    return int'(value);
  endfunction

  // Evolve the active window only; cells outside it keep their stored values.
  task automatic run_generation(input int nr, input int nc);
    logic [GRID_COLS-1:0] nxt [GRID_ROWS];
    int neighbors;
    int rr;
    int cc;
    nxt = cells;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        neighbors = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
              neighbors += int'(cells[rr][cc]);
          end
        end
        if (cells[r][c])
          nxt[r][c] = (neighbors == int'(NBR_KEEP)) || (neighbors == int'(NBR_BIRTH));
        else
          nxt[r][c] = (neighbors == int'(NBR_BIRTH));
      end
    end
    cells = nxt;
    if (gen_count != '1) gen_count++;
  endtask

  task automatic apply_command(input in_item_t cmd, output out_item_t res);
    int nr;
    int nc;
    logic empty;
    nr = active_size(rows_reg, GRID_ROWS);
    nc = active_size(cols_reg, GRID_COLS);
    res = '0;
    case (cmd.opcode)
      OP_WRITE, OP_READ: begin
        if (int'(cmd.row) >= nr || int'(cmd.col) >= nc)
          res.bad_index = 1'b1;
        else if (cmd.opcode == OP_WRITE)
          cells[cmd.row][cmd.col] = cmd.alive_in;
        else
          res.cell_alive = cells[cmd.row][cmd.col];
      end
      OP_STEP: run_generation(nr, nc);
      default: ;
    endcase
    empty = 1'b1;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (cells[r][c]) empty = 1'b0;
    res.all_dead   = empty;
    res.generation = gen_count;
  endtask

  task automatic report_field(input string name, input logic [GEN_W-1:0] want,
                              input logic [GEN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      foreach (cells[r]) cells[r] = '0;
      gen_count = '0;
      rows_reg  = CFG_RESET_VAL;
      cols_reg  = CFG_RESET_VAL;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: rows_reg = cfg_data;
          REG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      // Retire before predicting: a result never leaves in the cycle its command arrives.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("cell_alive", GEN_W'(want.cell_alive), GEN_W'(out_data.cell_alive));
          report_field("all_dead", GEN_W'(want.all_dead), GEN_W'(out_data.all_dead));
          report_field("generation", want.generation, out_data.generation);
          report_field("bad_index", GEN_W'(want.bad_index), GEN_W'(out_data.bad_index));
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_data, want);
        pending_results.push_back(want);
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the life grid testbench: clock, reset, command and register stimulus, verdict.
// Instantiates life_grid_generation and life_grid_checker; uses lgg_pkg types and codes.
module testbench;
  import lgg_pkg::*;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 75;
  // receiver hold-off: start once this many commands went in, last this many cycles
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;
  // window of accepted commands during which neither side idles
  localparam int CALM_FROM   = 450;
  localparam int CALM_TO     = 570;

  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int  errors;
  int  outstanding;
  int  accepted  = 0;
  int  cycles    = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  wire calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);

  // active window seen by the stimulus, plus a small hot spot where patterns grow
  int rows_eff = MAX_ROWS;
  int cols_eff = MAX_COLS;
  int win_r    = 0;
  int win_c    = 0;

  life_grid_generation #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  life_grid_checker monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL life_grid_generation");
      $finish;
    end
  end

  // Count command transfers; the hold-off and the calm window key off this.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) accepted <= accepted + 1;
  end

  // Result side: random stalls, one long hold-off so the block backs up into
  // its command channel, and no stalls inside the calm window.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  function automatic in_item_t cmd(input logic [1:0] op, input int r, input int c,
                                   input logic alive);
    in_item_t item;
    item.opcode   = op;
    item.row      = 6'(r);
    item.col      = 6'(c);
    item.alive_in = alive;
    return item;
  endfunction

  // Mostly in-window writes, reads and steps around the hot spot, so that real
  // patterns form and evolve; a few unused opcodes and out-of-range indexes.
  function automatic in_item_t random_command();
    in_item_t item;
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) < 7) begin
      item.row = 6'((win_r + $urandom_range(5)) % rows_eff);
      item.col = 6'((win_c + $urandom_range(5)) % cols_eff);
    end else begin
      item.row = 6'($urandom_range(rows_eff - 1));
      item.col = 6'($urandom_range(cols_eff - 1));
    end
    item.alive_in = ($urandom_range(9) < 6);
    if (pick < 40) begin
      item.opcode = OP_WRITE;
    end else if (pick < 68) begin
      item.opcode = OP_READ;
    end else if (pick < 84) begin
      item.opcode = OP_STEP;
    end else if (pick < 90) begin
      item.opcode = OP_UNUSED;
      item.row    = 6'($urandom_range(63));
      item.col    = 6'($urandom_range(63));
    end else begin
      item.opcode = $urandom_range(1) ? OP_WRITE : OP_READ;
      item.row    = 6'($urandom_range(63));
      item.col    = 6'($urandom_range(63));
    end
    return item;
  endfunction

  // Offer one command and hold it until transfer. Idle cycles go in front,
  // so valid drops only between commands.
  task automatic send(input in_item_t item);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has come back. The first
  // edge lets the checker's count catch up with the last command transfer.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Leave cfg_valid high for back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Resize only while the block is idle; optionally poke an unmapped index.
  task automatic set_grid_size(input logic [CFG_DATA_W-1:0] rows,
                               input logic [CFG_DATA_W-1:0] cols, input bit poke_spare);
    drain();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    if (poke_spare) write_reg(REG_SPARE, '1);
    cfg_valid <= 1'b0;
    rows_eff = (rows == '0) ? 1 : ((int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows));
    cols_eff = (cols == '0) ? 1 : ((int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols));
    win_r    = $urandom_range(rows_eff - 1);
    win_c    = $urandom_range(cols_eff - 1);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] phase_rows [PHASES];
    logic [CFG_DATA_W-1:0] phase_cols [PHASES];
    phase_rows = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd3, 7'd64, 7'd8, 7'd0, 7'd0, 7'd0};
    phase_cols = '{7'd64, 7'd1, 7'd0, 7'd7, 7'd64, 7'd3, 7'd8, 7'd127, 7'd0, 7'd0};
    phase_rows[8] = 7'($urandom_range(127));
    phase_cols[8] = 7'($urandom_range(127));
    phase_rows[9] = 7'($urandom_range(12, 1));
    phase_cols[9] = 7'($urandom_range(12, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Full grid at reset size: empty read, far corners, lone cells dying.
    send(cmd(OP_READ, 0, 0, 1'b0));
    send(cmd(OP_WRITE, 0, 0, 1'b1));
    send(cmd(OP_WRITE, 63, 63, 1'b1));
    send(cmd(OP_READ, 63, 63, 1'b0));
    send(cmd(OP_READ, 0, 0, 1'b0));
    send(cmd(OP_STEP, 0, 0, 1'b0));
    send(cmd(OP_UNUSED, 63, 63, 1'b1));
    // this cell falls outside the 3x3 window below and must stay put
    send(cmd(OP_WRITE, 10, 10, 1'b1));

    // Blinker in a 3x3 window: the border outside counts as dead.
    set_grid_size(7'd3, 7'd3, 1'b0);
    send(cmd(OP_WRITE, 1, 0, 1'b1));
    send(cmd(OP_WRITE, 1, 1, 1'b1));
    send(cmd(OP_WRITE, 1, 2, 1'b1));
    send(cmd(OP_STEP, 0, 0, 1'b0));
    send(cmd(OP_READ, 0, 1, 1'b0));
    send(cmd(OP_READ, 2, 1, 1'b0));
    send(cmd(OP_READ, 1, 0, 1'b0));
    send(cmd(OP_STEP, 0, 0, 1'b0));
    send(cmd(OP_READ, 1, 2, 1'b0));
    send(cmd(OP_WRITE, 3, 1, 1'b1));
    send(cmd(OP_READ, 0, 3, 1'b0));

    // Zero rows acts as one, oversize columns act as the maximum.
    set_grid_size(7'd0, 7'd127, 1'b1);
    send(cmd(OP_WRITE, 0, 63, 1'b1));
    send(cmd(OP_READ, 1, 0, 1'b0));
    send(cmd(OP_WRITE, 0, 62, 1'b1));
    send(cmd(OP_STEP, 0, 0, 1'b0));
    send(cmd(OP_READ, 0, 63, 1'b0));

    // Random phases over a spread of grid sizes; the grid carries over
    // between phases, so shrinking and regrowing exposes untouched cells.
    for (int p = 0; p < PHASES; p++) begin
      set_grid_size(phase_rows[p], phase_cols[p], p == 3);
      repeat (PHASE_ITEMS) send(random_command());
    end

    drain();
    repeat (MAX_ROWS + 16) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("PASS life_grid_generation");
    else
      $display("FAIL life_grid_generation");
    $finish;
  end

endmodule
